// ===== hdl/frame_deframer_crc_check_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Frame deframer assertion macros
// Shared concurrent assertion forms, clocked on aclk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef FRAME_DEFRAMER_CRC_CHECK_UNIT_DEFINES_SVH
`define FRAME_DEFRAMER_CRC_CHECK_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define FDC_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define FDC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/fdc_pkg.sv =====
// ----------------------------------------------------------------------------
// Frame deframer package
// Types, codes and the byte-wise CRC-32 update shared by the deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package fdc_pkg;

    // Default limit on the payload length in bytes.
    localparam int unsigned MAX_PAYLOAD_DEF = 65536;

    // Header layout: 20 bytes, the last one has index 19.
    localparam logic [4:0] HDR_LAST = 5'd19;

    // CRC-32 constants (reflected form).
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MAGIC   = 2'd0;
    localparam logic [1:0] CFG_VERSION = 2'd1;
    localparam logic [1:0] CFG_MAX_LEN = 2'd2;

    // Frame status codes.
    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_BAD_MAGIC   = 3'd1,
        ST_BAD_VERSION = 3'd2,
        ST_TOO_LARGE   = 3'd3,
        ST_BAD_CRC     = 3'd4
    } fdc_status_t;

    // Parser phase, one-hot.
    typedef enum logic [2:0] {
        PH_HEADER  = 3'b001,
        PH_PAYLOAD = 3'b010,
        PH_DEAD    = 3'b100
    } fdc_phase_t;

    // Configuration register contents.
    typedef struct packed {
        logic [31:0] expected_magic;
        logic [15:0] expected_version;
        logic [16:0] max_length;
    } fdc_cfg_t;

    // One result item.
    typedef struct packed {
        logic        has_byte;
        logic [7:0]  payload_byte;
        logic        end_of_frame;
        fdc_status_t status;
        logic [15:0] frame_type;
        logic [31:0] sequence_res;
        logic [16:0] frame_length;
    } fdc_result_t;

    // One byte of the reflected CRC-32, eight shift steps.
    function automatic logic [31:0] fdc_crc_byte(input logic [31:0] crc,
                                                 input logic [7:0]  data);
        logic [31:0] c;
        c = crc ^ {24'd0, data};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/frame_deframer_crc_check_unit.sv =====
// ----------------------------------------------------------------------------
// Frame deframer with CRC-32 check
// Parses a byte stream into length-prefixed frames with a 20-byte header.
// ----------------------------------------------------------------------------
// One stream byte is taken per cycle while s_ready is high; its result is
// registered for the next cycle. Header bytes give no result except
// the twentieth, which reports a failed check or an empty frame. Payload
// bytes are passed through, and the last one carries the frame status.
// The sustained rate is one byte per clock, set by the one-byte CRC update
// and the result register; s_ready drops only while a held result is not
// taken. A header check failure stops the parser until the next reset.
// Configuration writes are taken every cycle and must come while idle.
`default_nettype none

`include "frame_deframer_crc_check_unit_defines.svh"

module frame_deframer_crc_check_unit
    import fdc_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_has_byte,
    output logic [7:0]       m_payload_byte,
    output logic             m_end_of_frame,
    output logic [2:0]       m_status,
    output logic [15:0]      m_frame_type,
    output logic [31:0]      m_sequence_res,
    output logic [16:0]      m_frame_length
);

    fdc_cfg_t    cfg;
    fdc_result_t res;
    fdc_result_t m_res;
    logic        res_valid;
    logic        in_fire;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;
    assign in_fire   = s_valid && s_ready;

    fdc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_fire  (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    fdc_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .data_byte (s_data_byte),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    fdc_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .res_valid (res_valid),
        .res       (res),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_res     (m_res),
        .s_ready   (s_ready)
    );

    // Result fields to ports.
    assign m_has_byte     = m_res.has_byte;
    assign m_payload_byte = m_res.payload_byte;
    assign m_end_of_frame = m_res.end_of_frame;
    assign m_status       = m_res.status;
    assign m_frame_type   = m_res.frame_type;
    assign m_sequence_res = m_res.sequence_res;
    assign m_frame_length = m_res.frame_length;

    // Every result carries a byte or closes a frame.
    `FDC_ASSERT_IMPLIES(a_res_nonempty, m_valid, m_has_byte || m_end_of_frame, "empty result")
    // A failed frame never reports a length.
    `FDC_ASSERT_IMPLIES(a_fail_no_len, m_valid && m_status != ST_OK, m_frame_length == '0, "length on failure")
    // The input is only held off by a waiting result.
    `FDC_ASSERT_IMPLIES(a_stall_cause, !s_ready, m_valid && !m_ready, "stall without pending result")
    // A result accepted with no new one behind it leaves the register empty.
    `FDC_ASSERT_NEXT(a_drain, m_valid && m_ready && !(s_valid && res_valid), !m_valid, "result repeated")

endmodule

`default_nettype wire

// ===== hdl/fdc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Frame deframer configuration registers
// Holds the expected magic, expected version and length limit.
// ----------------------------------------------------------------------------
`default_nettype none

module fdc_cfg_regs
    import fdc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_fire,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    output fdc_cfg_t         cfg
);

    fdc_cfg_t cfg_reg;
    fdc_cfg_t cfg_next;

    // Decode the register index; unknown indexes are ignored.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_fire) begin
            unique case (cfg_index)
                CFG_MAGIC:   cfg_next.expected_magic   = cfg_data;
                CFG_VERSION: cfg_next.expected_version = cfg_data[15:0];
                CFG_MAX_LEN: cfg_next.max_length       = cfg_data[16:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    // Register update with reset values.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.expected_magic   <= '0;
            cfg_reg.expected_version <= '0;
            cfg_reg.max_length       <= 17'h10000;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== hdl/fdc_parser.sv =====
// ----------------------------------------------------------------------------
// Frame deframer parser
// Header capture, header checks, payload counting and CRC-32 per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module fdc_parser
    import fdc_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_fire,
    input  wire logic [7:0] data_byte,
    input  wire fdc_cfg_t   cfg,
    output logic            res_valid,
    output fdc_result_t     res
);

    localparam int unsigned    PLW     = $clog2(MAX_PAYLOAD + 1);
    localparam logic [31:0]    MAX_LEN = 32'(MAX_PAYLOAD);
    localparam logic [PLW-1:0] ONE     = PLW'(1);

    fdc_phase_t     phase_reg, phase_next;
    logic [4:0]     header_count_reg, header_count_next;
    logic [31:0]    magic_reg, magic_next;
    logic [15:0]    version_reg, version_next;
    logic [15:0]    type_reg, type_next;
    logic [31:0]    seq_reg, seq_next;
    logic [31:0]    length_reg, length_next;
    logic [31:0]    crc_seen_reg, crc_seen_next;
    logic [PLW-1:0] payload_left_reg, payload_left_next;
    logic [31:0]    running_crc_reg, running_crc_next;
    logic [31:0]    crc_calc;

    // CRC of the running value with the current byte.
    assign crc_calc = fdc_crc_byte(running_crc_reg, data_byte);

    // Next state and result for the accepted byte.
    always_comb begin
        phase_next        = phase_reg;
        header_count_next = header_count_reg;
        magic_next        = magic_reg;
        version_next      = version_reg;
        type_next         = type_reg;
        seq_next          = seq_reg;
        length_next       = length_reg;
        crc_seen_next     = crc_seen_reg;
        payload_left_next = payload_left_reg;
        running_crc_next  = running_crc_reg;
        res_valid         = 1'b0;
        res               = '0;
        res.status        = ST_OK;

        if (in_fire) begin
            unique case (phase_reg)
                PH_HEADER: begin
                    // Store the byte at its little-endian place in its field.
                    priority if (header_count_reg < 5'd4) begin
                        magic_next[header_count_reg[1:0]*8 +: 8] = data_byte;
                    end else if (header_count_reg < 5'd6) begin
                        version_next[header_count_reg[0]*8 +: 8] = data_byte;
                    end else if (header_count_reg < 5'd8) begin
                        type_next[header_count_reg[0]*8 +: 8] = data_byte;
                    end else if (header_count_reg < 5'd12) begin
                        seq_next[header_count_reg[1:0]*8 +: 8] = data_byte;
                    end else if (header_count_reg < 5'd16) begin
                        length_next[header_count_reg[1:0]*8 +: 8] = data_byte;
                    end else begin
                        crc_seen_next[header_count_reg[1:0]*8 +: 8] = data_byte;
                    end

                    if (header_count_reg != HDR_LAST) begin
                        header_count_next = header_count_reg + 5'd1;
                    end else begin
                        // Last header byte: run the checks in order.
                        header_count_next = '0;
                        res.frame_type    = type_reg;
                        res.sequence_res  = seq_reg;
                        priority if (magic_reg != cfg.expected_magic) begin
                            phase_next       = PH_DEAD;
                            res_valid        = 1'b1;
                            res.end_of_frame = 1'b1;
                            res.status       = ST_BAD_MAGIC;
                        end else if (version_reg != cfg.expected_version) begin
                            phase_next       = PH_DEAD;
                            res_valid        = 1'b1;
                            res.end_of_frame = 1'b1;
                            res.status       = ST_BAD_VERSION;
                        end else if (length_reg > MAX_LEN ||
                                     length_reg > {15'd0, cfg.max_length}) begin
                            phase_next       = PH_DEAD;
                            res_valid        = 1'b1;
                            res.end_of_frame = 1'b1;
                            res.status       = ST_TOO_LARGE;
                        end else if (length_reg == '0) begin
                            // Empty frame ends here without a CRC check.
                            res_valid        = 1'b1;
                            res.end_of_frame = 1'b1;
                            res.status       = ST_OK;
                        end else begin
                            payload_left_next = length_reg[PLW-1:0];
                            running_crc_next  = CRC_INIT;
                            phase_next        = PH_PAYLOAD;
                        end
                        if (!res_valid) begin
                            res.frame_type   = '0;
                            res.sequence_res = '0;
                        end
                    end
                end

                PH_PAYLOAD: begin
                    // Pass the byte through and update the CRC.
                    running_crc_next = crc_calc;
                    res_valid        = 1'b1;
                    res.has_byte     = 1'b1;
                    res.payload_byte = data_byte;
                    if (payload_left_reg > ONE) begin
                        payload_left_next = payload_left_reg - ONE;
                    end else begin
                        // Last payload byte closes the frame.
                        payload_left_next = '0;
                        phase_next        = PH_HEADER;
                        running_crc_next  = CRC_INIT;
                        res.end_of_frame  = 1'b1;
                        res.frame_type    = type_reg;
                        res.sequence_res  = seq_reg;
                        if ((crc_calc ^ CRC_INIT) == crc_seen_reg) begin
                            res.status       = ST_OK;
                            res.frame_length = length_reg[16:0];
                        end else begin
                            res.status = ST_BAD_CRC;
                        end
                    end
                end

                PH_DEAD: begin
                    // Bytes are dropped until reset.
                    phase_next = PH_DEAD;
                end

                default: begin
                    phase_next = PH_HEADER;
                end
            endcase
        end
    end

    // Control state takes reset; header fields are written before use.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_HEADER;
            header_count_reg <= '0;
            payload_left_reg <= '0;
            running_crc_reg  <= CRC_INIT;
        end else begin
            phase_reg        <= phase_next;
            header_count_reg <= header_count_next;
            payload_left_reg <= payload_left_next;
            running_crc_reg  <= running_crc_next;
        end
    end

    always_ff @(posedge aclk) begin
        magic_reg    <= magic_next;
        version_reg  <= version_next;
        type_reg     <= type_next;
        seq_reg      <= seq_next;
        length_reg   <= length_next;
        crc_seen_reg <= crc_seen_next;
    end

endmodule

`default_nettype wire

// ===== hdl/fdc_out_reg.sv =====
// ----------------------------------------------------------------------------
// Frame deframer result register
// Holds one result transaction and gives back-pressure to the input side.
// ----------------------------------------------------------------------------
`default_nettype none

module fdc_out_reg
    import fdc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_fire,
    input  wire logic        res_valid,
    input  wire fdc_result_t res,
    input  wire logic        m_ready,
    output logic             m_valid,
    output fdc_result_t      m_res,
    output logic             s_ready
);

    logic        valid_reg;
    logic        valid_next;
    fdc_result_t data_reg;

    // A new byte may enter when the register is empty or is being drained.
    assign s_ready = !valid_reg || m_ready;

    // Valid flag: set by a new result, cleared when taken.
    always_comb begin
        valid_next = valid_reg;
        if (in_fire && res_valid) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Result payload is loaded only with a new result.
    always_ff @(posedge aclk) begin
        if (in_fire && res_valid) begin
            data_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign m_res   = data_reg;

endmodule

`default_nettype wire

// ===== verif/frame_deframer_crc_check_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Frame deframer with CRC-32 check: testbench
// Feeds framed byte streams through the deframer, predicts each result from
// a behavioral copy of the parser and compares every returned transaction.
// ----------------------------------------------------------------------------
module frame_deframer_crc_check_unit_tb;
    import fdc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          HALF_PERIOD    = 4;
    localparam int          RESET_CYCLES   = 8;
    localparam int          HDR_BYTES      = 20;
    localparam int          SETTLE_CYCLES  = 4;
    localparam int          TAIL_CYCLES    = 16;
    localparam int          HOLDOFF_CYCLES = 250;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          DEAD_BYTES     = 24;
    localparam logic [1:0]  CFG_UNUSED     = 2'd3;
    localparam logic [31:0] CRC32_POLY     = 32'hEDB88320;

    logic        aclk           = 1'b0;
    logic        aresetn        = 1'b0;
    logic        cfg_valid      = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index      = '0;
    logic [31:0] cfg_data       = '0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte    = '0;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic        m_has_byte;
    logic [7:0]  m_payload_byte;
    logic        m_end_of_frame;
    logic [2:0]  m_status;
    logic [15:0] m_frame_type;
    logic [31:0] m_sequence_res;
    logic [16:0] m_frame_length;

    // Register copies as the block should hold them.
    logic [31:0] cfg_magic   = '0;
    logic [15:0] cfg_version = '0;
    logic [16:0] cfg_max_len = 17'd65536;

    // Parser state of the behavioral copy.
    fdc_phase_t  parse_phase = PH_HEADER;
    logic [4:0]  hdr_idx     = '0;
    logic [31:0] hdr_magic   = '0;
    logic [15:0] hdr_version = '0;
    logic [15:0] hdr_type    = '0;
    logic [31:0] hdr_seq     = '0;
    logic [31:0] hdr_length  = '0;
    logic [31:0] hdr_crc     = '0;
    logic [16:0] bytes_left  = '0;
    logic [31:0] crc_acc     = '1;

    fdc_result_t results_due[$];

    int          src_idle_pct    = 0;
    int          snk_idle_pct    = 0;
    int unsigned holdoff_cycles  = 0;
    int unsigned idle_cycles     = 0;
    int unsigned mismatch_count  = 0;
    int unsigned results_checked = 0;
    int unsigned bytes_sent      = 0;
    int unsigned frames_sent     = 0;
    int unsigned empty_frames    = 0;
    int unsigned crc_errors_sent = 0;
    fdc_status_t reject_kind     = ST_OK;

    frame_deframer_crc_check_unit dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_has_byte     (m_has_byte),
        .m_payload_byte (m_payload_byte),
        .m_end_of_frame (m_end_of_frame),
        .m_status       (m_status),
        .m_frame_type   (m_frame_type),
        .m_sequence_res (m_sequence_res),
        .m_frame_length (m_frame_length)
    );

    // Free-running clock, 8 ns period.
    always begin
        aclk = 1'b0;
        #HALF_PERIOD;
        aclk = 1'b1;
        #HALF_PERIOD;
    end

    // Reflected CRC-32, one data bit per step, LSB first.
    function automatic logic [31:0] crc32_next(input logic [31:0] crc, input logic [7:0] data);
        logic [31:0] c;
        logic        fb;
        int          i;
        c = crc;
        for (i = 0; i < 8; i++) begin
            fb = c[0] ^ data[i];
            c  = c >> 1;
            if (fb) begin
                c = c ^ CRC32_POLY;
            end
        end
        return c;
    endfunction

    // Closes a frame with the given status in the expected result stream.
    task automatic close_frame(input fdc_result_t base, input fdc_status_t st,
                               input logic [16:0] len);
        fdc_result_t r;
        r              = base;
        r.end_of_frame = 1'b1;
        r.status       = st;
        r.frame_type   = hdr_type;
        r.sequence_res = hdr_seq;
        r.frame_length = len;
        results_due.push_back(r);
    endtask

    // Advances the parser copy by one accepted stream byte.
    task automatic deframe_byte(input logic [7:0] b);
        fdc_result_t r;
        int          k;
        r = '0;
        k = hdr_idx;
        case (parse_phase)
            PH_HEADER: begin
                if (k < 4) hdr_magic[8*k +: 8] = b;
                else if (k < 6) hdr_version[8*(k-4) +: 8] = b;
                else if (k < 8) hdr_type[8*(k-6) +: 8] = b;
                else if (k < 12) hdr_seq[8*(k-8) +: 8] = b;
                else if (k < 16) hdr_length[8*(k-12) +: 8] = b;
                else hdr_crc[8*(k-16) +: 8] = b;
                if (k < HDR_BYTES - 1) begin
                    hdr_idx = hdr_idx + 5'd1;
                end else begin
                    // Header complete: magic, then version, then length.
                    hdr_idx = '0;
                    if (hdr_magic != cfg_magic) begin
                        parse_phase = PH_DEAD;
                        close_frame(r, ST_BAD_MAGIC, '0);
                    end else if (hdr_version != cfg_version) begin
                        parse_phase = PH_DEAD;
                        close_frame(r, ST_BAD_VERSION, '0);
                    end else if (hdr_length > MAX_PAYLOAD_DEF ||
                                 hdr_length > {15'd0, cfg_max_len}) begin
                        parse_phase = PH_DEAD;
                        close_frame(r, ST_TOO_LARGE, '0);
                    end else if (hdr_length == 0) begin
                        // An empty frame closes at once, no checksum compare.
                        close_frame(r, ST_OK, '0);
                    end else begin
                        bytes_left  = hdr_length[16:0];
                        crc_acc     = '1;
                        parse_phase = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                crc_acc        = crc32_next(crc_acc, b);
                r.has_byte     = 1'b1;
                r.payload_byte = b;
                if (bytes_left > 1) begin
                    bytes_left = bytes_left - 17'd1;
                    results_due.push_back(r);
                end else begin
                    bytes_left  = '0;
                    parse_phase = PH_HEADER;
                    if (~crc_acc == hdr_crc) close_frame(r, ST_OK, hdr_length[16:0]);
                    else close_frame(r, ST_BAD_CRC, '0);
                    crc_acc = '1;
                end
            end
            default: begin
                // Dead after a header reject: bytes vanish until reset.
            end
        endcase
    endtask

    // Offers one byte, with a random gap first, and holds it until taken.
    task automatic send_byte(input logic [7:0] b);
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_idle_pct);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        do @(posedge aclk); while (!s_ready);
        deframe_byte(b);
        bytes_sent++;
    endtask

    task automatic sender_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Stops the stream and waits until every expected result is back.
    task automatic settle();
        sender_idle();
        while (results_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_MAGIC:   cfg_magic   = value;
            CFG_VERSION: cfg_version = value[15:0];
            CFG_MAX_LEN: cfg_max_len = value[16:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic load_config(input logic [31:0] magic, input logic [31:0] version_word,
                               input logic [31:0] max_len_word);
        settle();
        write_register(CFG_MAGIC, magic);
        write_register(CFG_VERSION, version_word);
        write_register(CFG_MAX_LEN, max_len_word);
    endtask

    // Builds one frame (fill < 0 gives random payload) and streams it.
    task automatic send_frame(input logic [31:0] magic, input logic [15:0] version,
                              input logic [15:0] ftype, input logic [31:0] fseq,
                              input logic [31:0] flen, input bit good_crc, input int fill);
        logic [7:0]   body[$];
        logic [7:0]   b;
        logic [159:0] hdr;
        logic [31:0]  crc;
        logic [31:0]  crc_field;
        int unsigned  n;
        int unsigned  i;
        n   = (flen > MAX_PAYLOAD_DEF) ? 0 : flen;
        crc = '1;
        for (i = 0; i < n; i++) begin
            b   = (fill < 0) ? 8'($urandom) : 8'(fill);
            crc = crc32_next(crc, b);
            body.push_back(b);
        end
        if (n == 0) crc_field = $urandom;
        else if (good_crc) crc_field = ~crc;
        else crc_field = ~crc ^ (32'd1 << $urandom_range(31));
        hdr = {crc_field, flen, fseq, ftype, version, magic};
        for (i = 0; i < HDR_BYTES; i++) begin
            send_byte(hdr[8*i +: 8]);
        end
        foreach (body[j]) begin
            send_byte(body[j]);
        end
        frames_sent++;
        if (n == 0) empty_frames++;
        else if (!good_crc) crc_errors_sent++;
    endtask

    // Reset values of the registers: magic 0, version 0, limit 65536.
    task automatic test_reset_defaults();
        send_frame('0, '0, '0, '0, 0, 1'b1, -1);
        send_frame('0, '0, 16'($urandom), $urandom, 2, 1'b1, -1);
    endtask

    // Field extremes, checksum errors, empty frames and the length limit.
    task automatic test_directed_frames();
        load_config(32'hFFFF_FFFF, {16'($urandom), 16'hFFFF}, {15'($urandom), 17'h10000});
        send_frame(cfg_magic, cfg_version, 16'hFFFF, 32'hFFFF_FFFF, 1, 1'b1, 8'h00);
        send_frame(cfg_magic, cfg_version, 16'h0000, 32'h0000_0000, 1, 1'b0, 8'hFF);
        send_frame(cfg_magic, cfg_version, 16'hFFFF, 32'hFFFF_FFFF, 0, 1'b0, -1);
        send_frame(cfg_magic, cfg_version, 16'($urandom), $urandom, 8, 1'b1, 8'hFF);
        send_frame(cfg_magic, cfg_version, 16'($urandom), $urandom, 3, 1'b0, -1);

        // A length equal to the limit is still accepted.
        load_config('0, {16'($urandom), 16'h0000}, {15'($urandom), 17'd5});
        send_frame(cfg_magic, cfg_version, 16'($urandom), $urandom, 5, 1'b1, -1);
        send_frame(cfg_magic, cfg_version, 16'($urandom), $urandom, 5, 1'b0, -1);

        // With a zero limit only empty frames pass.
        load_config($urandom, $urandom, {15'($urandom), 17'd0});
        send_frame(cfg_magic, cfg_version, 16'($urandom), $urandom, 0, 1'b1, -1);

        // A write to the unused index leaves every register alone.
        settle();
        write_register(CFG_UNUSED, $urandom);
        send_frame(cfg_magic, cfg_version, 16'($urandom), $urandom, 0, 1'b1, -1);
    endtask

    // Well-formed frames with random content; a share carry a bad checksum.
    task automatic test_random_frames(input int unsigned byte_budget,
                                      input logic [31:0] max_len_word,
                                      input int unsigned len_cap);
        int unsigned start;
        int unsigned cap;
        int unsigned plen;
        int unsigned pick;
        load_config($urandom, $urandom, max_len_word);
        cap   = (len_cap < cfg_max_len) ? len_cap : cfg_max_len;
        start = bytes_sent;
        while (bytes_sent - start < byte_budget) begin
            pick = $urandom_range(9);
            if (pick < 6) plen = $urandom_range(16);
            else if (pick < 9) plen = $urandom_range(64, 17);
            else plen = ($urandom_range(1) != 0) ? cap : $urandom_range(len_cap);
            if (plen > cap) plen = cap;
            send_frame(cfg_magic, cfg_version, 16'($urandom), $urandom, plen,
                       $urandom_range(99) < 85, -1);
        end
    endtask

    // The receiver holds off while the sender keeps offering payload.
    task automatic test_output_backpressure();
        holdoff_cycles = HOLDOFF_CYCLES;
        send_frame(cfg_magic, cfg_version, 16'($urandom), $urandom, 120, 1'b1, -1);
        settle();
    endtask

    // One header check fails; the parser then discards everything.
    task automatic test_header_reject();
        logic [31:0] magic;
        logic [31:0] flen;
        logic [15:0] version;
        reject_kind = fdc_status_t'($urandom_range(ST_TOO_LARGE, ST_BAD_MAGIC));
        load_config($urandom, $urandom, {15'($urandom), 17'($urandom_range(100, 1))});
        magic   = cfg_magic;
        version = cfg_version;
        flen    = $urandom_range(cfg_max_len);
        case (reject_kind)
            ST_BAD_MAGIC: begin
                // A wrong version too must still report the magic first.
                magic = cfg_magic ^ (32'd1 << $urandom_range(31));
                if ($urandom_range(1) != 0) version = ~cfg_version;
            end
            ST_BAD_VERSION: begin
                version = cfg_version ^ (16'd1 << $urandom_range(15));
                if ($urandom_range(1) != 0) flen = 32'hFFFF_FFFF;
            end
            default: begin
                if ($urandom_range(1) != 0) begin
                    flen = {15'd0, cfg_max_len} + 32'd1;
                end else begin
                    // The register allows more than the block ever takes.
                    write_register(CFG_MAX_LEN, 32'h0001_FFFF);
                    flen = ($urandom_range(1) != 0) ? 32'($urandom_range(131071, 65537))
                                                    : ($urandom | 32'h0002_0000);
                end
            end
        endcase
        send_frame(magic, version, 16'($urandom), $urandom, flen, 1'b1, -1);
        repeat (DEAD_BYTES) send_byte(8'($urandom));
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
        end
    endtask

    // Result side: random stalls, plus a long hold-off when one is requested.
    always @(posedge aclk) begin
        if (holdoff_cycles != 0) begin
            m_ready        <= 1'b0;
            holdoff_cycles <= holdoff_cycles - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Compare each result transaction against the oldest expectation.
    always @(posedge aclk) begin : result_check
        fdc_result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_checked++;
            if (results_due.size() == 0) begin
                mismatch_count++;
                $display({"%0t: unexpected result, expected none, ",
                          "actual byte=%0d/0x%0h eof=%0d status=%0d"},
                         $time, m_has_byte, m_payload_byte, m_end_of_frame, m_status);
            end else begin
                want = results_due.pop_front();
                check_field("has_byte", want.has_byte, m_has_byte);
                check_field("payload_byte", want.payload_byte, m_payload_byte);
                check_field("end_of_frame", want.end_of_frame, m_end_of_frame);
                check_field("status", want.status, m_status);
                check_field("frame_type", want.frame_type, m_frame_type);
                check_field("sequence_res", want.sequence_res, m_sequence_res);
                check_field("frame_length", want.frame_length, m_frame_length);
            end
        end
    end

    // Watchdog: too long without any transaction on any channel.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Sender mostly busy, receiver stalling often.
        src_idle_pct = 9;
        snk_idle_pct = 55;
        test_reset_defaults();
        test_directed_frames();
        test_random_frames(250, {15'($urandom), 17'd300}, 300);

        // Sender gapping often, receiver mostly ready.
        settle();
        src_idle_pct = 55;
        snk_idle_pct = 9;
        test_random_frames(250, {15'($urandom), 17'd40}, 300);

        // Full rate on both sides.
        settle();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_random_frames(250, 32'h0001_FFFF, 300);
        test_output_backpressure();
        test_header_reject();

        settle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        $display({"Covered %0d frames (%0d empty, %0d with a bad checksum), ",
                  "%0d bytes in, %0d results checked."},
                 frames_sent, empty_frames, crc_errors_sent, bytes_sent, results_checked);
        $display("The run closed on a %s header reject followed by discarded bytes.",
                 reject_kind.name());
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
